@@ hdl/rpr_pkg.sv @@
// Package for the debug-link packet receiver.
// Holds framing characters, event codes, phase codes, the result record
// and the hex digit decoder. No dependencies.
package rpr_pkg;

   // Framing and acknowledge characters
   localparam logic [7:0] CH_START = 8'h24;   // '$'
   localparam logic [7:0] CH_END   = 8'h23;   // '#'
   localparam logic [7:0] CH_ACK   = 8'h2B;   // '+'
   localparam logic [7:0] CH_NAK   = 8'h2D;   // '-'
   localparam logic [7:0] CH_NONE  = 8'h00;

   // Payload limit after reset: one less than the packet buffer size
   localparam int unsigned BUFFER_SIZE = 1000;
   localparam logic [9:0]  LIMIT_RESET = 10'(BUFFER_SIZE - 1);

   // Event codes on the result channel
   localparam logic [2:0] EV_IGNORED = 3'd0;
   localparam logic [2:0] EV_PAYLOAD = 3'd1;
   localparam logic [2:0] EV_ACCEPT  = 3'd2;
   localparam logic [2:0] EV_BAD_SUM = 3'd3;
   localparam logic [2:0] EV_RESTART = 3'd4;
   localparam logic [2:0] EV_ABANDON = 3'd5;

   // Receiver phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_HI   = 2'd2;
   localparam logic [1:0] PH_LO   = 2'd3;

   // One result item
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] payload_byte;
      logic [7:0] ack_byte;
      logic [9:0] packet_length;
   } rpr_result_type;

   // Decode one ASCII hex digit; anything else reads as 0xFF
   function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
      logic [7:0] value;
      if (c >= 8'h61 && c <= 8'h66) begin
         value = c - 8'h57;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         value = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         value = c - 8'h37;
      end else begin
         value = 8'hFF;
      end
      return value;
   endfunction

endpackage

@@ hdl/rpr_frame_ctrl.sv @@
// Framing state machine of the packet receiver: phase, running checksum,
// payload count and first checksum digit, plus the per-byte result logic.
// Depends on rpr_pkg.
module rpr_frame_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rx_byte,
   input  logic [9:0]              payload_limit,
   output rpr_pkg::rpr_result_type result
);
   import rpr_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [9:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;

   logic [9:0] count_inc;
   logic [7:0] sum_add;
   logic [7:0] digit;
   logic [7:0] rx_sum;

   assign count_inc = count_ff + 10'd1;
   assign sum_add   = sum_ff + rx_byte;
   assign digit     = hex_digit_value(rx_byte);
   assign rx_sum    = first_ff + digit;

   // Next state and result for the byte at hand
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      first_in = first_ff;
      result   = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == CH_START) begin
               phase_in = PH_DATA;
               sum_in   = '0;
               count_in = '0;
            end
            result.event_res = EV_IGNORED;
         end
         PH_DATA: begin
            if (rx_byte == CH_START) begin
               sum_in           = '0;
               count_in         = '0;
               result.event_res = EV_RESTART;
            end else if (rx_byte == CH_END) begin
               phase_in             = PH_HI;
               result.packet_length = count_ff;
            end else begin
               sum_in               = sum_add;
               count_in             = count_inc;
               result.payload_byte  = rx_byte;
               result.packet_length = count_inc;
               if (count_inc >= payload_limit) begin
                  result.event_res = EV_ABANDON;
                  phase_in         = PH_IDLE;
               end else begin
                  result.event_res = EV_PAYLOAD;
               end
            end
         end
         PH_HI: begin
            first_in             = {digit[3:0], 4'h0};
            phase_in             = PH_LO;
            result.packet_length = count_ff;
         end
         PH_LO: begin
            if (rx_sum == sum_ff) begin
               result.event_res = EV_ACCEPT;
               result.ack_byte  = CH_ACK;
            end else begin
               result.event_res = EV_BAD_SUM;
               result.ack_byte  = CH_NAK;
            end
            phase_in             = PH_IDLE;
            result.packet_length = count_ff;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance the state on each byte that moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         first_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   // The high checksum digit is always followed by the low one
   a_hi_then_lo: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_HI |=> phase_ff == PH_LO)
      else $error("high checksum digit not followed by low digit phase");

   // The low digit always closes the packet
   a_lo_then_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_LO |=> phase_ff == PH_IDLE)
      else $error("packet not closed after low checksum digit");

   // An ack byte goes out exactly with a checksum verdict
   a_ack_event: assert property (@(posedge clock) disable iff (reset)
      (result.ack_byte != CH_NONE) ==
      (result.event_res == EV_ACCEPT || result.event_res == EV_BAD_SUM))
      else $error("ack byte and checksum event disagree");

   // Abandoning a packet returns to waiting for the start byte
   a_abandon_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.event_res == EV_ABANDON |=> phase_ff == PH_IDLE)
      else $error("abandoned packet left the receiver busy");

endmodule

@@ hdl/rsp_packet_receiver_unit.sv @@
// Top level of the debug-link packet receiver: input register, framing
// logic, result register and the payload limit register.
// Depends on rpr_pkg and rpr_frame_ctrl.
// A transferred byte goes into the input register and then, once the
// result register is free or draining, into the result register, raising rsp_valid.
// Throughput: one byte per cycle; the input register refills while the
// result register drains, so only a stalled result channel slows it.
// Reset (synchronous, active high) empties both registers, sets the
// payload limit to 999 and returns the framing logic to waiting for '$'.
module rsp_packet_receiver_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_ack_byte,
   output logic [9:0] rsp_packet_length,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_payload_limit
);
   import rpr_pkg::*;

   logic           in_vld_ff;
   logic [7:0]     in_byte_ff;
   logic           out_vld_ff;
   rpr_result_type out_ff;
   rpr_result_type step_result;
   logic [9:0]     limit_ff;
   logic           advance;

   // Move the held byte on when the result register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   // Payload limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_payload_limit;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   rpr_frame_ctrl u_frame_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .rx_byte       (in_byte_ff),
      .payload_limit (limit_ff),
      .result        (step_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_ack_byte      = out_ff.ack_byte;
   assign rsp_packet_length = out_ff.packet_length;

   // A held byte waits while the result channel is stalled
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ready |=> in_vld_ff && $stable(in_byte_ff))
      else $error("held byte lost while result channel stalled");

   // Every byte that moves on yields a valid result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("advanced byte produced no result");

   // With both registers full and no drain, nothing new is taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline full");

endmodule
